### rtl/core/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: word types, decoder state and lead-byte decode.
// No dependencies. Imported by every module of the block.
`default_nettype none
package u8sd_pkg;

   localparam int unsigned COUNT_W = 17;

   // Counters saturate at the smaller of the string byte limit and the field maximum.
   localparam logic [COUNT_W-1:0] COUNT_BOUND   = 17'h10000;
   localparam logic [COUNT_W-1:0] COUNT_INVALID = 17'h1FFFF;
   localparam logic [1:0]         CONT_TAG      = 2'b10;

   localparam logic [2:0] LEN_BAD = 3'd0;
   localparam logic [2:0] LEN_1   = 3'd1;
   localparam logic [2:0] LEN_2   = 3'd2;
   localparam logic [2:0] LEN_3   = 3'd3;
   localparam logic [2:0] LEN_4   = 3'd4;
   localparam logic [2:0] LEN_5   = 3'd5;
   localparam logic [2:0] LEN_6   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [31:0]        code_point;
      logic               char_done;
      logic               bad_sequence;
      logic               string_end;
      logic [COUNT_W-1:0] char_total;
      logic [COUNT_W-1:0] byte_total;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]        partial_value;
      logic [2:0]         bytes_remaining;
      logic [2:0]         sequence_length;
      logic               error_seen;
      logic               error_reported;
      logic [COUNT_W-1:0] char_counter;
      logic [COUNT_W-1:0] byte_counter;
   } dec_state_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (!b[7])                  len = LEN_1;
      else if (b[7:2] == 6'h3F)   len = LEN_6;
      else if (b[7:3] == 5'h1F)   len = LEN_5;
      else if (b[7:4] == 4'hF)    len = LEN_4;
      else if (b[7:5] == 3'h7)    len = LEN_3;
      else if (b[7:6] == 2'h3)    len = LEN_2;
      else                        len = LEN_BAD;
      return len;
   endfunction

   function automatic logic [7:0] lead_mask(input logic [2:0] len);
      logic [7:0] m;
      unique case (len)
         LEN_1:   m = 8'h7F;
         LEN_2:   m = 8'h3F;
         LEN_3:   m = 8'h1F;
         LEN_4:   m = 8'h0F;
         LEN_5:   m = 8'h07;
         LEN_6:   m = 8'h03;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/core/u8sd_step.sv
// Per-byte decode step: next decoder state and the result word for one byte.
// Depends on u8sd_pkg.
`default_nettype none
module u8sd_step
   import u8sd_pkg::*;
(
   input  wire dec_state_type state_cur,
   input  wire req_word_type  word,
   output dec_state_type      state_next,
   output rsp_word_type       rsp,
   output logic               emit
);

   always_comb begin
      dec_state_type     nxt;
      logic              bad;
      logic              done;
      logic [31:0]       cp;
      logic [2:0]        len;
      logic [COUNT_W:0]  byte_sum;

      nxt      = state_cur;
      bad      = 1'b0;
      done     = 1'b0;
      cp       = 32'd0;
      len      = lead_length(word.data_byte);
      byte_sum = '0;

      if (!state_cur.error_seen) begin
         if (state_cur.bytes_remaining == 3'd0) begin
            if (len == LEN_BAD) begin
               bad = 1'b1;
            end else begin
               nxt.partial_value   = {24'd0, word.data_byte & lead_mask(len)};
               nxt.sequence_length = len;
               nxt.bytes_remaining = len - 3'd1;
            end
         end else if (word.data_byte[7:6] != CONT_TAG) begin
            bad = 1'b1;
         end else begin
            nxt.partial_value   = {state_cur.partial_value[25:0], word.data_byte[5:0]};
            nxt.bytes_remaining = state_cur.bytes_remaining - 3'd1;
         end

         if (!bad && nxt.bytes_remaining == 3'd0) begin
            done = 1'b1;
            cp   = nxt.partial_value;
            if (state_cur.char_counter < COUNT_BOUND) begin
               nxt.char_counter = state_cur.char_counter + 17'd1;
            end
            byte_sum = {1'b0, state_cur.byte_counter} + {15'd0, nxt.sequence_length};
            nxt.byte_counter = (byte_sum > {1'b0, COUNT_BOUND}) ? COUNT_BOUND
                                                                : byte_sum[COUNT_W-1:0];
            nxt.partial_value   = 32'd0;
            nxt.sequence_length = 3'd0;
         end

         if (!bad && word.end_of_text && nxt.bytes_remaining != 3'd0) begin
            bad = 1'b1;
         end
         if (bad) begin
            nxt.error_seen = 1'b1;
         end
      end

      emit = done || word.end_of_text || (nxt.error_seen && !state_cur.error_reported);

      rsp.code_point   = nxt.error_seen ? 32'd0 : cp;
      rsp.char_done    = nxt.error_seen ? 1'b0 : done;
      rsp.bad_sequence = nxt.error_seen;
      rsp.string_end   = word.end_of_text;
      rsp.char_total   = nxt.error_seen ? COUNT_INVALID : nxt.char_counter;
      rsp.byte_total   = nxt.error_seen ? COUNT_INVALID : nxt.byte_counter;

      if (emit && nxt.error_seen) begin
         nxt.error_reported = 1'b1;
      end
      if (word.end_of_text) begin
         nxt = '0;
      end

      state_next = nxt;
   end

endmodule
`default_nettype wire

### rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decoder state, result register.
// Depends on u8sd_pkg and u8sd_step.
//
// Usage:
//   The req channel carries one string byte per word, with end_of_text set on
//   the last byte of each string. The rsp channel carries at most one word per
//   byte: on a completed character, on the first error of a string, and on the
//   final byte of every string (with the character and byte counts).
//   Both channels move a word at a clock edge with valid high and stall low.
//   Throughput is one byte per cycle while rsp_stall is low; the decode of a
//   byte is a single pass through the step logic between the input register and
//   the result register.
//   When rsp_stall is held, the pending result holds, the byte in the input
//   register waits, and req_stall rises once that register is full.
//   Synchronous reset empties both registers and clears the decoder state;
//   the block takes bytes in the cycle after reset is released.
`default_nettype none
module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  wire req_word_type  req_word,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output rsp_word_type  rsp_word
);

   req_word_type  req_ff;
   logic          req_valid_ff, req_valid_in;
   dec_state_type state_ff, state_in;
   rsp_word_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance, fire, accept, emit;

   u8sd_step u_step (
      .state_cur  (state_ff),
      .word       (req_ff),
      .state_next (state_in),
      .rsp        (rsp_in),
      .emit       (emit)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept)       req_valid_in = 1'b1;
      else if (advance) req_valid_in = 1'b0;
      else              req_valid_in = req_valid_ff;
   end

   always_comb begin
      if (fire)            rsp_valid_in = emit;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

### rtl/core/u8sd_checker.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on u8sd_pkg and utf8_stream_decoder.
`default_nettype none
module u8sd_checker
   import u8sd_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          rsp_valid,
   input wire          rsp_stall,
   input wire rsp_word_type rsp_word
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_sequence |->
         !rsp_word.char_done && rsp_word.code_point == 32'd0 &&
         rsp_word.char_total == COUNT_INVALID && rsp_word.byte_total == COUNT_INVALID)
      else $error("error result carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.bad_sequence |->
         rsp_word.char_total <= rsp_word.byte_total && rsp_word.byte_total <= COUNT_BOUND)
      else $error("counts inconsistent");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
`default_nettype wire
